// ----- hw/rtl/ftm_pkg.sv -----
// ----------------------------------------------------------------------------
// ftm_pkg
// Shared types and constants for the frame timing monitor: request codes,
// fixed-point weights, the slot word layout and the arithmetic unit control.
// ----------------------------------------------------------------------------
`default_nettype none

package ftm_pkg;

  // Default number of timer slots; the last slot is the total slot.
  localparam int SLOT_COUNT_DEFAULT = 8;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_LAP       = 3'd0;
  localparam logic [2:0] REQ_LAP_TOTAL = 3'd1;
  localparam logic [2:0] REQ_FRAME     = 3'd2;
  localparam logic [2:0] REQ_CLEAR     = 3'd3;
  localparam logic [2:0] REQ_READ      = 3'd4;

  // Q0.16 smoothing weights; they sum to exactly 1.0.
  localparam logic [15:0] W_KEEP = 16'd65208;
  localparam logic [15:0] W_NEW  = 16'd328;

  // Accumulator width: a 16 x 32 product plus rounding fits in 48 bits.
  localparam int ACC_W = 48;
  localparam logic [ACC_W-1:0] ROUND_HALF = 48'd32768;

  // Reset value of the averaged frame period, 1333.33 us in Q24.8.
  localparam logic [31:0] PERIOD_RESET = 32'd341333;

  // Elapsed time saturates to 24 bits of whole microseconds.
  localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;

  // CPU load is Q4.12, one quotient bit per divide step.
  localparam int          LOAD_W    = 16;
  localparam int          DIV_STEPS = LOAD_W;
  localparam logic [15:0] LOAD_MAX  = 16'hFFFF;

  // One slot entry of the statistics memory.
  typedef struct packed {
    logic [31:0] avg;
    logic [31:0] peak;
    logic [31:0] max;
  } slot_word_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_MAC_FIRST,
    ALU_MAC_NEXT,
    ALU_DIV_INIT,
    ALU_DIV_STEP
  } alu_op_t;

  // Control bundle from the sequencer to the arithmetic unit.
  typedef struct packed {
    alu_op_t     op;
    logic [15:0] w;
    logic [31:0] x;
    logic [31:0] y;
  } alu_ctrl_t;

  // Elapsed time since the frame start, saturated and moved to Q24.8.
  function automatic logic [31:0] elapsed_q(input logic [31:0] now,
                                            input logic [31:0] start);
    logic [31:0] d;
    logic [23:0] s;
    d = now - start;
    s = (d[31:24] != 8'd0) ? ELAPSED_MAX : d[23:0];
    return {s, 8'h00};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ftm_if.sv -----
// ----------------------------------------------------------------------------
// ftm_if
// Valid/ready channels of the frame timing monitor: the request channel and
// the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  timer_index;
  logic [31:0] now_us;

  modport source (output valid, output req_type, output timer_index, output now_us,
                  input ready);
  modport sink (input valid, input req_type, input timer_index, input now_us,
                output ready);
endinterface

interface ftm_rsp_if;
  logic        valid;
  logic        ready;
  logic        index_ok;
  logic [31:0] avg_time;
  logic [31:0] peak_time;
  logic [31:0] max_time;
  logic [31:0] frame_period;
  logic [15:0] cpu_load;

  modport source (output valid, output index_ok, output avg_time, output peak_time,
                  output max_time, output frame_period, output cpu_load,
                  input ready);
  modport sink (input valid, input index_ok, input avg_time, input peak_time,
                input max_time, input frame_period, input cpu_load,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ftm_alu.sv -----
// ----------------------------------------------------------------------------
// ftm_alu
// Shared arithmetic unit: a 16 x 32 multiply-accumulate with round-half-up
// seeding, and a restoring divider that yields one quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ftm_alu
  import ftm_pkg::*;
(
  input  wire logic              clk,
  input  wire alu_ctrl_t         ctrl,
  output logic      [ACC_W-1:0]  acc,
  output logic      [LOAD_W-1:0] load
);

  logic [ACC_W-1:0]  prod;
  logic [31:0]       rem;
  logic [31:0]       divisor;
  logic [15:0]       low_bits;
  logic [LOAD_W-1:0] quot;
  logic              sat;
  logic [32:0]       trial;
  logic              fits;

  // One multiplier; its result lands in the accumulator register on the multiply-accumulate operations.
  assign prod = ACC_W'(ctrl.w) * ACC_W'(ctrl.x);

  // Shift the next dividend bit into the remainder and test the divisor.
  assign trial = {rem, low_bits[15]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    case (ctrl.op)
      ALU_MAC_FIRST: acc <= ROUND_HALF + prod;
      ALU_MAC_NEXT:  acc <= acc + prod;
      ALU_DIV_INIT: begin
        // Dividend is peak << 12; the upper part seeds the remainder.
        rem      <= {4'd0, ctrl.x[31:4]};
        low_bits <= {ctrl.x[3:0], 12'd0};
        divisor  <= ctrl.y;
        quot     <= '0;
        // Quotient would not fit in 16 bits (also covers a zero period).
        sat      <= ({4'd0, ctrl.x} >= {ctrl.y, 4'd0});
      end
      ALU_DIV_STEP: begin
        rem      <= fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
        low_bits <= {low_bits[14:0], 1'b0};
        quot     <= {quot[LOAD_W-2:0], fits};
      end
      default: begin
      end
    endcase
  end

  assign load = sat ? LOAD_MAX : quot;

endmodule

`default_nettype wire

// ----- hw/rtl/ftm_slot_mem.sv -----
// ----------------------------------------------------------------------------
// ftm_slot_mem
// Per-slot statistics memory (average, peak, maximum) with one write port,
// one registered read port and reset-cleared valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ftm_slot_mem
  import ftm_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
  parameter int SW         = $clog2(SLOT_COUNT)
)(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [SW-1:0] waddr,
  input  wire slot_word_t    wdata,
  input  wire logic          re,
  input  wire logic [SW-1:0] raddr,
  output slot_word_t         rdata
);

  slot_word_t            mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;
  slot_word_t            rd_word;
  logic                  rd_valid;

  // Storage and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_word <= mem[raddr];
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/frame_timing_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// frame_timing_monitor_unit
// Processing-time monitor: slot laps, frame resets, clears and reads, with
// smoothed averages, decaying peaks, maxima and a CPU load figure.
// ----------------------------------------------------------------------------
// The block takes one request at a time. req is ready again once the
// result is registered. After every request the divider recomputes the
// CPU load: one setup step and sixteen bit-per-step passes. Laps and later
// frame resets also pass through the single 16 x 32 multiply-accumulate
// unit that blends averages, decays peaks and smooths the frame period.
// The result sits in an output register, so a new request is taken while
// the previous result still waits to be read.
`default_nettype none

module frame_timing_monitor_unit
  import ftm_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)(
  input wire logic  clk,
  input wire logic  rst,
  ftm_req_if.sink   req,
  ftm_rsp_if.source rsp
);

  localparam int          SW      = $clog2(SLOT_COUNT);
  localparam logic [7:0]  N_SLOTS = 8'(SLOT_COUNT);
  localparam logic [7:0]  N_LAPS  = 8'(SLOT_COUNT - 1);
  localparam logic [SW-1:0] LAST  = SW'(SLOT_COUNT - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AVG0  = 4'd1;
  localparam logic [3:0] S_AVG1  = 4'd2;
  localparam logic [3:0] S_PK    = 4'd3;
  localparam logic [3:0] S_WB    = 4'd4;
  localparam logic [3:0] S_PER0  = 4'd5;
  localparam logic [3:0] S_PER1  = 4'd6;
  localparam logic [3:0] S_PERWB = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;
  localparam logic [3:0] S_RDX   = 4'd9;
  localparam logic [3:0] S_DIV0  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [3:0]  cnt;
  logic        accept;

  logic [SW-1:0] in_slot;
  logic          in_ok;

  logic [SW-1:0] slot;
  logic          res_ok;
  logic [31:0]   res_avg;
  logic [31:0]   res_peak;
  logic [31:0]   res_max;
  logic [31:0]   sample;
  logic [31:0]   avg_new;
  logic [31:0]   period;
  logic [31:0]   frame_start;
  logic          started;
  logic [31:0]   total_peak;

  logic          out_valid;
  logic          out_ok;
  logic [31:0]   out_avg;
  logic [31:0]   out_peak;
  logic [31:0]   out_max;
  logic [31:0]   out_period;
  logic [15:0]   out_load;

  alu_ctrl_t         alu_ctrl;
  logic [ACC_W-1:0]  acc;
  logic [LOAD_W-1:0] load;
  logic [31:0]       acc_q;
  logic [31:0]       peak_new;
  logic [31:0]       max_new;

  logic          mem_we;
  slot_word_t    mem_wdata;
  slot_word_t    rd;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign acc_q     = acc[47:16];

  // Decode the addressed slot of an incoming request.
  always_comb begin
    in_slot = req.timer_index[SW-1:0];
    in_ok   = 1'b0;
    unique case (req.req_type) inside
      REQ_LAP:            in_ok = (req.timer_index < N_LAPS);
      REQ_LAP_TOTAL: begin
        in_slot = LAST;
        in_ok   = 1'b1;
      end
      REQ_FRAME:          in_ok = 1'b1;
      REQ_CLEAR, REQ_READ: in_ok = (req.timer_index < N_SLOTS);
      default:            in_ok = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DIV0;
          case (req.req_type) inside
            REQ_LAP, REQ_LAP_TOTAL: if (in_ok) state_next = S_AVG0;
            REQ_FRAME:              if (started) state_next = S_PER0;
            REQ_CLEAR:              if (in_ok) state_next = S_CLR;
            REQ_READ:               if (in_ok) state_next = S_RDX;
            default:                state_next = S_DIV0;
          endcase
        end
      end
      S_AVG0:  state_next = S_AVG1;
      S_AVG1:  state_next = S_PK;
      S_PK:    state_next = S_WB;
      S_WB:    state_next = S_DIV0;
      S_PER0:  state_next = S_PER1;
      S_PER1:  state_next = S_PERWB;
      S_PERWB: state_next = S_DIV0;
      S_CLR:   state_next = S_DIV0;
      S_RDX:   state_next = S_DIV0;
      S_DIV0:  state_next = S_DIV;
      S_DIV: begin
        if (cnt == 4'(DIV_STEPS - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Arithmetic unit control for each step.
  always_comb begin
    alu_ctrl = '{op: ALU_NOP, w: W_KEEP, x: '0, y: '0};
    unique case (state) inside
      S_AVG0: begin
        alu_ctrl.op = ALU_MAC_FIRST;
        alu_ctrl.x  = rd.avg;
      end
      S_AVG1, S_PER1: begin
        alu_ctrl.op = ALU_MAC_NEXT;
        alu_ctrl.w  = W_NEW;
        alu_ctrl.x  = sample;
      end
      S_PK: begin
        alu_ctrl.op = ALU_MAC_FIRST;
        alu_ctrl.x  = rd.peak;
      end
      S_PER0: begin
        alu_ctrl.op = ALU_MAC_FIRST;
        alu_ctrl.x  = period;
      end
      S_DIV0: begin
        alu_ctrl.op = ALU_DIV_INIT;
        alu_ctrl.x  = total_peak;
        alu_ctrl.y  = period;
      end
      S_DIV:   alu_ctrl.op = ALU_DIV_STEP;
      default: alu_ctrl.op = ALU_NOP;
    endcase
  end

  // New peak and maximum of a lap.
  assign peak_new = (sample > acc_q) ? sample : acc_q;
  assign max_new  = (sample > rd.max) ? sample : rd.max;

  // Slot memory write: lap write-back or clear.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    if (state == S_WB) begin
      mem_we    = 1'b1;
      mem_wdata = '{avg: avg_new, peak: peak_new, max: max_new};
    end else if (state == S_CLR) begin
      mem_we = 1'b1;
    end
  end

  ftm_alu u_alu (
    .clk  (clk),
    .ctrl (alu_ctrl),
    .acc  (acc),
    .load (load)
  );

  ftm_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .SW         (SW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (slot),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_slot),
    .rdata (rd)
  );

  // Control state and the monitor's global registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      period      <= PERIOD_RESET;
      frame_start <= '0;
      started     <= 1'b0;
      total_peak  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV0) begin
        cnt <= '0;
      end else if (state == S_DIV) begin
        cnt <= cnt + 4'd1;
      end
      if (accept && req.req_type == REQ_FRAME) begin
        frame_start <= req.now_us;
        started     <= 1'b1;
      end
      if (state == S_PERWB) begin
        period <= acc_q;
      end
      if (state == S_WB && slot == LAST) begin
        total_peak <= peak_new;
      end else if (state == S_CLR && slot == LAST) begin
        total_peak <= '0;
      end
      if (state == S_FIN && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-request working registers and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      slot     <= in_slot;
      res_ok   <= in_ok;
      sample   <= elapsed_q(req.now_us, frame_start);
      res_avg  <= '0;
      res_peak <= '0;
      res_max  <= '0;
    end
    if (state == S_PK) begin
      avg_new <= acc_q;
    end
    if (state == S_WB) begin
      res_avg  <= avg_new;
      res_peak <= peak_new;
      res_max  <= max_new;
    end
    if (state == S_RDX) begin
      res_avg  <= rd.avg;
      res_peak <= rd.peak;
      res_max  <= rd.max;
    end
    if (state == S_FIN && (!out_valid || rsp.ready)) begin
      out_ok     <= res_ok;
      out_avg    <= res_avg;
      out_peak   <= res_peak;
      out_max    <= res_max;
      out_period <= period;
      out_load   <= load;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.index_ok     = out_ok;
  assign rsp.avg_time     = out_avg;
  assign rsp.peak_time    = out_peak;
  assign rsp.max_time     = out_max;
  assign rsp.frame_period = out_period;
  assign rsp.cpu_load     = out_load;

endmodule

`default_nettype wire

// ----- hw/rtl/ftm_checker.sv -----
// ----------------------------------------------------------------------------
// ftm_checker
// Port-level checks of the frame timing monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ftm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        index_ok,
  input wire logic [31:0] avg_time,
  input wire logic [31:0] peak_time,
  input wire logic [31:0] max_time,
  input wire logic [31:0] frame_period,
  input wire logic [15:0] cpu_load
);

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while an item was in progress");

  // A rejected request reports no slot values.
  a_rejected_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !index_ok) |-> (avg_time == 32'd0 && peak_time == 32'd0 &&
                                  max_time == 32'd0))
    else $error("slot values shown on a rejected request");

  // A zero period always saturates the load.
  a_zero_period_load: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && frame_period == 32'd0) |-> (cpu_load == 16'hFFFF))
    else $error("load not saturated for a zero period");

  // The decaying peak never exceeds the maximum since clear.
  a_peak_below_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (peak_time <= max_time))
    else $error("peak above maximum");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(avg_time) &&
                                   $stable(cpu_load) && $stable(frame_period)))
    else $error("result changed while stalled");

endmodule

bind frame_timing_monitor_unit ftm_checker u_ftm_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .index_ok     (rsp.index_ok),
  .avg_time     (rsp.avg_time),
  .peak_time    (rsp.peak_time),
  .max_time     (rsp.max_time),
  .frame_period (rsp.frame_period),
  .cpu_load     (rsp.cpu_load)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for frame_timing_monitor_unit. A table of directed
// requests covers reset values, out-of-range indexes, unknown operations,
// saturation and wrap of the microsecond clock, and the first frame reset.
// Well-formed frames with random laps follow, mixed with random noise
// requests. Fixed table rows carry their report; an in-bench model of the
// slot statistics predicts the rest. Each response item is compared field
// by field against its report while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ftm_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEFAULT;
  localparam int RANDOM_ITEMS = 400;

  // Smoothing weights and reset values, Q0.16 and Q24.8.
  localparam logic [63:0] KEEP_W = 64'd65208;
  localparam logic [63:0] FRESH_W = 64'd328;
  localparam logic [63:0] HALF_LSB = 64'd32768;
  localparam logic [31:0] START_PERIOD = 32'd341333;
  localparam logic [31:0] SAT_US = 32'h00FF_FFFF;

  // Request codes that the block does not define.
  localparam logic [2:0] REQ_RSVD_5 = 3'd5;
  localparam logic [2:0] REQ_RSVD_6 = 3'd6;
  localparam logic [2:0] REQ_RSVD_7 = 3'd7;

  typedef struct packed {
    logic        ok;
    logic [31:0] avg_q;
    logic [31:0] peak_q;
    logic [31:0] max_q;
    logic [31:0] period_q;
    logic [15:0] load_q;
  } slot_report_t;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  idx;
    logic [31:0] now;
    bit          fixed;
    logic        fixed_ok;
  } stim_row_t;

  logic clk;
  logic rst;

  ftm_req_if req_ch ();
  ftm_rsp_if rsp_ch ();

  frame_timing_monitor_unit DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the monitor state.
  logic [31:0] avg_tab [SLOTS];
  logic [31:0] peak_tab [SLOTS];
  logic [31:0] max_tab [SLOTS];
  logic [31:0] frame_t0;
  logic        frame_running;
  logic [31:0] period_avg_q;

  slot_report_t pending_reports[$];
  stim_row_t    directed_rows[$];
  int unsigned  error_count = 0;
  int unsigned  accepted_count = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Weighted blend of an old value and a new sample, rounded half up.
  function automatic logic [31:0] smooth(input logic [31:0] old, input logic [31:0] sample);
    logic [63:0] s;
    s = KEEP_W * {32'd0, old} + FRESH_W * {32'd0, sample} + HALF_LSB;
    return s[47:16];
  endfunction

  // Elapsed microseconds since the frame start, saturated, in Q24.8.
  function automatic logic [31:0] since_start(input logic [31:0] now);
    logic [31:0] d;
    d = now - frame_t0;
    if (d > SAT_US) d = SAT_US;
    return d << 8;
  endfunction

  function automatic void record_lap(input int unsigned slot, input logic [31:0] now);
    logic [31:0] sample;
    logic [63:0] decayed;
    sample = since_start(now);
    avg_tab[slot] = smooth(avg_tab[slot], sample);
    decayed = KEEP_W * {32'd0, peak_tab[slot]} + HALF_LSB;
    peak_tab[slot] = (sample > decayed[47:16]) ? sample : decayed[47:16];
    if (sample > max_tab[slot]) max_tab[slot] = sample;
  endfunction

  // Applies one request to the shadow state and returns the report it yields.
  function automatic slot_report_t apply_request(input logic [2:0] op, input logic [7:0] idx,
                                                 input logic [31:0] now);
    slot_report_t r;
    logic         shown;
    int unsigned  slot;
    logic [63:0]  ratio;
    r = '0;
    shown = 1'b0;
    slot = 0;
    case (op)
      REQ_LAP: begin
        if (idx < SLOTS - 1) begin
          slot = idx;
          record_lap(slot, now);
          r.ok = 1'b1;
          shown = 1'b1;
        end
      end
      REQ_LAP_TOTAL: begin
        slot = SLOTS - 1;
        record_lap(slot, now);
        r.ok = 1'b1;
        shown = 1'b1;
      end
      REQ_FRAME: begin
        if (!frame_running) begin
          frame_running = 1'b1;
        end else begin
          period_avg_q = smooth(period_avg_q, since_start(now));
        end
        frame_t0 = now;
        r.ok = 1'b1;
      end
      REQ_CLEAR: begin
        if (idx < SLOTS) begin
          slot = idx;
          avg_tab[slot] = '0;
          peak_tab[slot] = '0;
          max_tab[slot] = '0;
          r.ok = 1'b1;
          shown = 1'b1;
        end
      end
      REQ_READ: begin
        if (idx < SLOTS) begin
          slot = idx;
          r.ok = 1'b1;
          shown = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (shown) begin
      r.avg_q = avg_tab[slot];
      r.peak_q = peak_tab[slot];
      r.max_q = max_tab[slot];
    end
    r.period_q = period_avg_q;
    // The load is the total slot's peak over the period, in Q4.12.
    if (period_avg_q == '0) begin
      r.load_q = 16'hFFFF;
    end else begin
      ratio = ({32'd0, peak_tab[SLOTS-1]} << 12) / {32'd0, period_avg_q};
      r.load_q = (ratio > 64'd65535) ? 16'hFFFF : ratio[15:0];
    end
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [7:0] idx,
                                  input logic [31:0] now, input bit fixed,
                                  input logic fixed_ok);
    stim_row_t row;
    row.op = op;
    row.idx = idx;
    row.now = now;
    row.fixed = fixed;
    row.fixed_ok = fixed_ok;
    directed_rows.push_back(row);
  endfunction

  // Presents one request, waits for the handshake and queues its report.
  // A fixed row carries its report in the table; the model still tracks it.
  task automatic issue_request(input logic [2:0] op, input logic [7:0] idx,
                               input logic [31:0] now, input bit fixed = 1'b0,
                               input logic fixed_ok = 1'b0);
    slot_report_t r;
    int unsigned  gap;
    int unsigned  pick;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.timer_index <= idx;
    req_ch.now_us <= now;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = apply_request(op, idx, now);
    if (fixed) begin
      r = '0;
      r.ok = fixed_ok;
      r.period_q = START_PERIOD;
    end
    pending_reports.push_back(r);
    accepted_count++;
    // Mostly back to back or short gaps, now and then a long one.
    pick = $urandom_range(0, 99);
    if (pick < 50) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 3);
    else if (pick < 95) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 80);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Response checker: each accepted item against the oldest prediction.
  always @(posedge clk) begin
    slot_report_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected response item, actual ok %b avg %h peak %h max %h",
                 $time, rsp_ch.index_ok, rsp_ch.avg_time, rsp_ch.peak_time,
                 rsp_ch.max_time);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        report_field("index_ok", {31'd0, want.ok}, {31'd0, rsp_ch.index_ok});
        report_field("avg_time", want.avg_q, rsp_ch.avg_time);
        report_field("peak_time", want.peak_q, rsp_ch.peak_time);
        report_field("max_time", want.max_q, rsp_ch.max_time);
        report_field("frame_period", want.period_q, rsp_ch.frame_period);
        report_field("cpu_load", {16'd0, want.load_q}, {16'd0, rsp_ch.cpu_load});
      end
    end
  end

  // Response side back-pressure: ready stretches broken by random stalls.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 40)) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        rsp_ch.ready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
        else repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main stimulus.
  initial begin
    logic [31:0] clock_us;
    int unsigned laps;
    int unsigned frame_len;
    int unsigned random_end;
    bit          drained;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_READ;
    req_ch.timer_index <= '0;
    req_ch.now_us <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      avg_tab[i] = '0;
      peak_tab[i] = '0;
      max_tab[i] = '0;
    end
    frame_t0 = '0;
    frame_running = 1'b0;
    period_avg_q = START_PERIOD;

    // Reset values, bad indexes and unknown operations, all before any lap.
    add_row(REQ_READ, 8'd0, 32'd0, 1'b1, 1'b1);
    add_row(REQ_READ, 8'(SLOTS - 1), 32'd0, 1'b1, 1'b1);
    add_row(REQ_READ, 8'(SLOTS), 32'd0, 1'b1, 1'b0);
    add_row(REQ_READ, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_row(REQ_CLEAR, 8'(SLOTS), 32'd0, 1'b1, 1'b0);
    add_row(REQ_CLEAR, 8'hFF, 32'd0, 1'b1, 1'b0);
    add_row(REQ_LAP, 8'(SLOTS - 1), 32'd100, 1'b1, 1'b0);
    add_row(REQ_LAP, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_row(REQ_RSVD_5, 8'd0, 32'd0, 1'b1, 1'b0);
    add_row(REQ_RSVD_6, 8'd3, 32'h5555_AAAA, 1'b1, 1'b0);
    add_row(REQ_RSVD_7, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    // The first frame reset only records the start time.
    add_row(REQ_FRAME, 8'd0, 32'h0000_1000, 1'b1, 1'b1);
    // Laps: ordinary, zero elapsed, total slot, saturated, wrapped clock.
    add_row(REQ_LAP, 8'd0, 32'h0000_1000 + 32'd700, 1'b0, 1'b0);
    add_row(REQ_LAP, 8'(SLOTS - 2), 32'h0000_1000, 1'b0, 1'b0);
    add_row(REQ_LAP_TOTAL, 8'hFF, 32'h0000_1000 + 32'd1200, 1'b0, 1'b0);
    add_row(REQ_LAP_TOTAL, 8'd0, 32'h0100_1000, 1'b0, 1'b0);
    add_row(REQ_LAP, 8'd3, 32'h0000_0FFF, 1'b0, 1'b0);
    add_row(REQ_READ, 8'(SLOTS - 1), 32'd0, 1'b0, 1'b0);
    // Later frame resets: normal, saturated, wrapped.
    add_row(REQ_FRAME, 8'd0, 32'h0000_1000 + 32'd1333, 1'b0, 1'b0);
    add_row(REQ_FRAME, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(REQ_FRAME, 8'd7, 32'd5, 1'b0, 1'b0);
    add_row(REQ_CLEAR, 8'(SLOTS - 1), 32'd0, 1'b0, 1'b0);
    add_row(REQ_CLEAR, 8'd0, 32'd0, 1'b0, 1'b0);
    add_row(REQ_LAP, 8'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_row(REQ_READ, 8'd3, 32'd0, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].now,
                    directed_rows[i].fixed, directed_rows[i].fixed_ok);
    end

    // Random frames: a frame reset, a few laps, the total lap, sometimes a
    // read or clear, with some noise requests in between.
    clock_us = $urandom;
    drained = 1'b0;
    random_end = accepted_count + RANDOM_ITEMS;
    while (accepted_count < random_end) begin
      if (!drained && accepted_count >= random_end - RANDOM_ITEMS / 2) begin
        // Hold off until every outstanding response has come back.
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 12) begin
        issue_request(3'($urandom_range(0, 7)), 8'($urandom), $urandom);
      end else begin
        frame_len = $urandom_range(500, 3000);
        if ($urandom_range(0, 19) == 0) clock_us = $urandom;
        else clock_us += frame_len;
        issue_request(REQ_FRAME, 8'($urandom), clock_us);
        laps = $urandom_range(1, 6);
        for (int k = 0; k < laps; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            issue_request(REQ_LAP, 8'($urandom_range(0, SLOTS - 2)), $urandom);
          end else begin
            issue_request(REQ_LAP, 8'($urandom_range(0, SLOTS - 2)),
                          clock_us + $urandom_range(0, frame_len));
          end
        end
        issue_request(REQ_LAP_TOTAL, 8'($urandom), clock_us + $urandom_range(0, frame_len));
        if ($urandom_range(0, 3) == 0) begin
          issue_request(($urandom_range(0, 4) == 0) ? REQ_CLEAR : REQ_READ,
                        8'($urandom_range(0, SLOTS - 1)), $urandom);
        end
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ftm_pkg.sv
hw/rtl/ftm_if.sv
hw/rtl/ftm_alu.sv
hw/rtl/ftm_slot_mem.sv
hw/rtl/frame_timing_monitor_unit.sv
hw/rtl/ftm_checker.sv
sim/tb_top.sv
